/* src/imhdk_pkg.sv */
// Package: shared constants and types for the indexed min-heap.
`timescale 1ns / 1ps
package imhdk_pkg;
	localparam int NODES    = 256;
	localparam int KEY_BITS = 32;
	localparam int IDX_W    = $clog2(NODES);
	localparam int CNT_W    = $clog2(NODES + 1);

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_POP = 1'b1;

	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [KEY_BITS-1:0] key_t;

	// One word to the output side.
	typedef struct packed {
		logic [7:0]  node_id_res;
		logic [31:0] distance_res;
		logic        popped;
		logic        error;
		logic        heap_empty;
	} res_t;
endpackage

/* src/imhdk_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM, registered read.
`timescale 1ns / 1ps
module imhdk_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* src/indexed_min_heap_decrease_key.sv */
// Top level: indexed binary min-heap with decrease-key, stream channels.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one command word: tdata[0] command (0 add/lower, 1 pop),
//   tdata[8:1] node_id, tdata[40:9] distance. m_axis returns exactly one result
//   word per command: tdata[7:0] node_id_res, tdata[39:8] distance_res;
//   tuser[0] popped, tuser[1] error, tuser[2] heap_empty.
//   Heap slots, the position map, keys and the per-node entered/removed flags
//   sit in synchronous RAMs with registered reads.
//   A sequencer walks the heap one level at a time. A sift-up level reads the
//   parent slot, then the parent key, then compares and swaps; a sift-down
//   level reads the left slot, then the left key and the right slot, then the
//   right key, then picks and swaps. A walk moves at most 8 levels for 256
//   entries; an empty pop answers with the error flag set and no walk.
//   One command is worked at a time; s_tready is high only in idle, so a new
//   command is taken only after the result of the last one has been taken.
//   The result sits in output registers; if the receiver stalls, hold it and
//   take no new command until it drains.
//   Reset (arst_n low) empties the heap and drops any pending result; after
//   reset a pass over the 256 nodes clears the flag RAM with s_tready held low.
module indexed_min_heap_decrease_key
	import imhdk_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // command, node_id, distance, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // node_id_res, distance_res
	output logic [7:0]  m_tuser    // popped, error, heap_empty, zero fill
);
	localparam logic [3:0] ST_CLR = 4'd0, ST_IDLE = 4'd1, ST_CMD = 4'd2,
		ST_UP0 = 4'd3, ST_UP1 = 4'd4, ST_UP2 = 4'd5, ST_POP1 = 4'd6,
		ST_POP2 = 4'd7, ST_DN0 = 4'd8, ST_DN1 = 4'd9, ST_DN2 = 4'd10,
		ST_DN3 = 4'd11, ST_OUT = 4'd12;

	// Per-node flag codes: never entered, in the heap, popped.
	localparam logic [1:0] FLG_NONE = 2'b00, FLG_ENTERED = 2'b01, FLG_REMOVED = 2'b11;

	logic [3:0] state_q;
	idx_t clr_q;
	cnt_t count_q;
	logic cmd_q;
	idx_t node_q;
	key_t dist_q;
	idx_t pos_q, par_q;
	key_t key_x_q, key_l_q;
	idx_t node_p_q, node_l_q, node_r_q;
	logic [7:0]  res_node_q;
	logic [31:0] res_dist_q;
	logic res_pop_q, res_err_q;

	// RAM ports
	logic hs_we, sn_we, kn_we, fl_we;
	idx_t hs_wa, hs_ra, sn_wa, sn_ra, kn_wa, kn_ra, fl_wa, fl_ra;
	idx_t hs_wd, sn_wd, hs_rd, sn_rd;
	key_t kn_wd, kn_rd;
	logic [1:0] fl_wd, fl_rd;

	logic in_cmd;
	idx_t in_node;
	key_t in_dist;

	idx_t parent_c, left_c, right_c, last_c, best_pos;
	cnt_t left_w;
	logic right_ok, right_lt, best_lt;
	idx_t best_node;
	key_t best_key;

	imhdk_ram #(.W(IDX_W), .D(NODES)) u_slots (.clk, .we(hs_we), .waddr(hs_wa),
		.wdata(hs_wd), .raddr(hs_ra), .rdata(hs_rd));
	imhdk_ram #(.W(IDX_W), .D(NODES)) u_pos (.clk, .we(sn_we), .waddr(sn_wa),
		.wdata(sn_wd), .raddr(sn_ra), .rdata(sn_rd));
	imhdk_ram #(.W(KEY_BITS), .D(NODES)) u_key (.clk, .we(kn_we), .waddr(kn_wa),
		.wdata(kn_wd), .raddr(kn_ra), .rdata(kn_rd));
	imhdk_ram #(.W(2), .D(NODES)) u_flags (.clk, .we(fl_we), .waddr(fl_wa),
		.wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd));

	assign in_cmd  = s_tdata[0];
	assign in_node = s_tdata[8:1];
	assign in_dist = s_tdata[40:9];

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {res_dist_q, res_node_q};
	// count is final while the result waits, so empty is read straight off it
	assign m_tuser  = {5'd0, (count_q == '0), res_err_q, res_pop_q};

	assign parent_c = (pos_q - idx_t'(1)) >> 1;
	assign left_w   = {pos_q, 1'b1};
	assign left_c   = left_w[IDX_W-1:0];
	assign right_c  = left_c + idx_t'(1);
	assign last_c   = idx_t'(count_q - cnt_t'(1));

	// Child pick: right only when strictly smaller, so the left child wins ties.
	assign right_ok  = (left_w + cnt_t'(1)) < count_q;
	assign right_lt  = right_ok && (kn_rd < key_l_q);
	assign best_node = right_lt ? node_r_q : node_l_q;
	assign best_key  = right_lt ? kn_rd : key_l_q;
	assign best_pos  = right_lt ? right_c : left_c;
	assign best_lt   = best_key < key_x_q;

	// RAM addressing by state; read data arrives in the cycle after the address.
	always_comb begin
		hs_we = 1'b0; hs_wa = pos_q;  hs_wd = node_q;  hs_ra = pos_q;
		sn_we = 1'b0; sn_wa = node_q; sn_wd = pos_q;   sn_ra = in_node;
		kn_we = 1'b0; kn_wa = node_q; kn_wd = key_x_q; kn_ra = node_q;
		fl_we = 1'b0; fl_wa = node_q; fl_wd = FLG_NONE; fl_ra = in_node;
		unique case (state_q)
			ST_CLR: begin
				fl_we = 1'b1;
				fl_wa = clr_q;
			end
			ST_IDLE: begin
				// fetch flags, slot and key of the offered node, plus the root
				hs_ra = '0;
				kn_ra = in_node;
			end
			ST_CMD: begin
				if (cmd_q == CMD_ADD) begin
					if (fl_rd == FLG_ENTERED) begin
						kn_we = 1'b1;
						kn_wd = (dist_q < kn_rd) ? dist_q : kn_rd;
					end else if (fl_rd == FLG_NONE && count_q < cnt_t'(NODES)) begin
						// append at the end of the heap
						hs_we = 1'b1; hs_wa = idx_t'(count_q);
						sn_we = 1'b1; sn_wd = idx_t'(count_q);
						kn_we = 1'b1; kn_wd = dist_q;
						fl_we = 1'b1; fl_wd = FLG_ENTERED;
					end
				end else begin
					// root node on hs_rd: fetch its key and the last slot
					hs_ra = last_c;
					kn_ra = hs_rd;
				end
			end
			ST_UP0: begin
				// settle our node at its current slot, fetch the parent slot
				hs_we = 1'b1;
				sn_we = 1'b1;
				hs_ra = parent_c;
			end
			ST_UP1: kn_ra = hs_rd;
			ST_UP2: if (key_x_q < kn_rd) begin
				// parent moves down into our slot
				hs_we = 1'b1; hs_wd = node_p_q;
				sn_we = 1'b1; sn_wa = node_p_q;
			end
			ST_POP1: begin
				fl_we = 1'b1; fl_wa = node_p_q; fl_wd = FLG_REMOVED;
				kn_ra = hs_rd;
			end
			ST_DN0: begin
				hs_we = 1'b1;
				sn_we = 1'b1;
				hs_ra = left_c;
			end
			ST_DN1: begin
				kn_ra = hs_rd;
				hs_ra = right_c;
			end
			ST_DN2: kn_ra = hs_rd;
			ST_DN3: if (best_lt) begin
				// smaller child moves up into our slot
				hs_we = 1'b1; hs_wd = best_node;
				sn_we = 1'b1; sn_wa = best_node;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			count_q    <= '0;
			cmd_q      <= CMD_ADD;
			node_q     <= '0;
			dist_q     <= '0;
			pos_q      <= '0;
			par_q      <= '0;
			key_x_q    <= '0;
			key_l_q    <= '0;
			node_p_q   <= '0;
			node_l_q   <= '0;
			node_r_q   <= '0;
			res_node_q <= '0;
			res_dist_q <= '0;
			res_pop_q  <= 1'b0;
			res_err_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + idx_t'(1);
					if (clr_q == idx_t'(NODES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (s_tvalid) begin
					cmd_q      <= in_cmd;
					node_q     <= in_node;
					dist_q     <= in_dist;
					res_node_q <= '0;
					res_dist_q <= '0;
					res_pop_q  <= 1'b0;
					res_err_q  <= 1'b0;
					state_q    <= ST_CMD;
				end
				ST_CMD: begin
					if (cmd_q == CMD_ADD) begin
						if (fl_rd == FLG_ENTERED) begin
							// keep the smaller key and sift up from its slot
							key_x_q <= (dist_q < kn_rd) ? dist_q : kn_rd;
							pos_q   <= sn_rd;
							state_q <= ST_UP0;
						end else if (fl_rd == FLG_NONE && count_q < cnt_t'(NODES)) begin
							key_x_q <= dist_q;
							pos_q   <= idx_t'(count_q);
							count_q <= count_q + cnt_t'(1);
							state_q <= ST_UP0;
						end else begin
							// popped before: drop the command
							state_q <= ST_OUT;
						end
					end else if (count_q == '0) begin
						res_err_q <= 1'b1;
						state_q   <= ST_OUT;
					end else begin
						node_p_q <= hs_rd;
						state_q  <= ST_POP1;
					end
				end
				ST_UP0: begin
					if (pos_q == '0) state_q <= ST_OUT;
					else begin
						par_q   <= parent_c;
						state_q <= ST_UP1;
					end
				end
				ST_UP1: begin
					node_p_q <= hs_rd;
					state_q  <= ST_UP2;
				end
				ST_UP2: begin
					if (key_x_q < kn_rd) begin
						pos_q   <= par_q;
						state_q <= ST_UP0;
					end else state_q <= ST_OUT;
				end
				ST_POP1: begin
					// root key on kn_rd, last node on hs_rd
					res_node_q <= node_p_q;
					res_dist_q <= kn_rd;
					res_pop_q  <= 1'b1;
					count_q    <= count_q - cnt_t'(1);
					node_q     <= hs_rd;
					pos_q      <= '0;
					if (count_q == cnt_t'(1)) state_q <= ST_OUT;
					else state_q <= ST_POP2;
				end
				ST_POP2: begin
					key_x_q <= kn_rd;
					state_q <= ST_DN0;
				end
				ST_DN0: begin
					if (left_w >= count_q) state_q <= ST_OUT;
					else state_q <= ST_DN1;
				end
				ST_DN1: begin
					node_l_q <= hs_rd;
					state_q  <= ST_DN2;
				end
				ST_DN2: begin
					key_l_q  <= kn_rd;
					node_r_q <= hs_rd;
					state_q  <= ST_DN3;
				end
				ST_DN3: begin
					if (best_lt) begin
						pos_q   <= best_pos;
						state_q <= ST_DN0;
					end else state_q <= ST_OUT;
				end
				ST_OUT: if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
